/* rtl/ssg_pkg.sv */
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants for the substitution sequence generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DataW   = 32;

  localparam logic [CfgIdxW-1:0] REG_VARIANT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BIT_LIMIT = 2'd1;

  localparam logic [DataW-1:0] LIMIT_RESET = 32'd1024;
  localparam logic [DataW-1:0] EMIT_MAX    = 32'hFFFF_FFFF;

  localparam logic       VAR_TERNARY = 1'b0;
  localparam logic       VAR_BINARY  = 1'b1;

  localparam logic [7:0] MASK_TERNARY = 8'h0F;
  localparam logic [7:0] MASK_BINARY  = 8'hFF;
  localparam int unsigned NOISE_BIT   = 7;

  localparam logic [1:0] DIGIT_ONE = 2'd1;
  localparam logic [1:0] DIGIT_TWO = 2'd2;

  // status a digit cell hands to its neighbor and to the encoder
  typedef struct packed {
    logic carry_out;   // advance ripples past this cell
    logic stop;        // advance lands on this cell
    logic stop_on_one; // landed digit was 1
  } ssg_cell_stat_t;

  // one result word
  typedef struct packed {
    logic bit_val;
    logic inverted;
    logic finished;
  } ssg_result_t;

endpackage

/* rtl/substitution_sequence_generator.sv */
// ----------------------------------------------------------------------------
// substitution_sequence_generator
// Chacon substitution bit sequence, one result word per random byte.
// Throughput: one byte per cycle while the skid register is empty; the digit
// carry ripples through the cell row within the cycle and the next word sees the updated digits.
// Output register plus a skid register keep input ready while a word waits.
// Reset: synchronous, clears digits, counters, done latch and output/skid valid flags.
// ----------------------------------------------------------------------------
module substitution_sequence_generator #(
  parameter int unsigned STAGES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ssg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ssg_pkg::DataW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rand_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_bit,
  output logic                          out_inverted_bit,
  output logic                          out_finished
);

  localparam int unsigned PW = $clog2(STAGES + 1);

  logic                      variant_r;
  logic [ssg_pkg::DataW-1:0] limit_r;
  logic [PW-1:0]             pending_r;
  logic [PW-1:0]             pending_nxt;
  logic [ssg_pkg::DataW-1:0] emitted_r;
  logic [ssg_pkg::DataW-1:0] emitted_nxt;
  logic                      done_r;
  logic                      done_nxt;

  logic                      accept;
  logic                      advance;
  logic                      overflow;
  logic [PW-1:0]             pending_new;
  logic [7:0]                mask;
  logic                      noise;
  logic                      emit;
  ssg_pkg::ssg_result_t      res;

  ssg_pkg::ssg_result_t      out_r;
  logic                      out_valid_r;
  ssg_pkg::ssg_result_t      skid_r;
  logic                      skid_valid_r;

  assign in_ready = ~skid_valid_r;
  assign accept   = in_valid & in_ready;

  assign mask  = (variant_r == ssg_pkg::VAR_BINARY) ? ssg_pkg::MASK_BINARY
                                                    : ssg_pkg::MASK_TERNARY;
  assign noise = ((in_rand_byte & mask) == 8'd0) ? in_rand_byte[ssg_pkg::NOISE_BIT] : 1'b0;

  ssg_digit_chain #(
    .STAGES (STAGES),
    .PW     (PW)
  ) u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .variant     (variant_r),
    .overflow    (overflow),
    .pending_new (pending_new)
  );

  always_comb begin
    pending_nxt = pending_r;
    done_nxt    = done_r;
    advance     = 1'b0;
    emit        = 1'b0;
    res         = '0;
    if (pending_r != '0) begin
      pending_nxt  = pending_r - PW'(1);
      emit         = 1'b1;
      res.bit_val  = ~noise;
      res.inverted = 1'b1;
    end else if (done_r || (emitted_r >= limit_r)) begin
      done_nxt     = 1'b1;
      res.finished = 1'b1;
    end else begin
      emit        = 1'b1;
      advance     = accept;
      res.bit_val = noise;
      pending_nxt = pending_new;
      if (overflow) begin
        done_nxt = 1'b1;
      end
    end
    emitted_nxt = (emit && emitted_r != ssg_pkg::EMIT_MAX) ? emitted_r + 32'd1 : emitted_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= ssg_pkg::VAR_TERNARY;
      limit_r   <= ssg_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ssg_pkg::REG_VARIANT:   variant_r <= cfg_data[0];
        ssg_pkg::REG_BIT_LIMIT: limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      emitted_r <= '0;
      done_r    <= 1'b0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      emitted_r <= emitted_nxt;
      done_r    <= done_nxt;
    end
  end

  // output word register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bit          = out_r.bit_val;
  assign out_inverted_bit = out_r.inverted;
  assign out_finished     = out_r.finished;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with output register empty");

  a_done_latched: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("done latch released without reset");

  a_pending_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pending_r != '0) |=> (pending_r == $past(pending_r) - PW'(1)))
    else $error("pending count did not drop by one on an inverted word");

  a_finished_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.finished) |-> (!out_r.bit_val && !out_r.inverted))
    else $error("finished word carries a bit");

endmodule

/* rtl/ssg_digit_cell.sv */
// ----------------------------------------------------------------------------
// ssg_digit_cell
// One counter digit. Clears when the carry ripples through it, increments
// when the carry stops here.
// ----------------------------------------------------------------------------
module ssg_digit_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic                    variant,
  input  logic                    carry_in,
  output ssg_pkg::ssg_cell_stat_t stat
);

  logic [1:0] digit_r;
  logic [1:0] digit_nxt;
  logic       prop;

  // ternary passes on a 2, binary passes on a 1
  assign prop = (variant == ssg_pkg::VAR_BINARY) ? (digit_r == ssg_pkg::DIGIT_ONE)
                                                 : (digit_r == ssg_pkg::DIGIT_TWO);

  assign stat.carry_out   = carry_in & prop;
  assign stat.stop        = carry_in & ~prop;
  assign stat.stop_on_one = carry_in & ~prop & (digit_r == ssg_pkg::DIGIT_ONE);

  always_comb begin
    digit_nxt = digit_r;
    if (advance && carry_in) begin
      digit_nxt = prop ? 2'd0 : digit_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= 2'd0;
    end else begin
      digit_r <= digit_nxt;
    end
  end

endmodule

/* rtl/ssg_digit_chain.sv */
// ----------------------------------------------------------------------------
// ssg_digit_chain
// Row of digit cells, least significant first, plus the encoder that turns
// the carry pattern into a pending count of inverted words.
// ----------------------------------------------------------------------------
module ssg_digit_chain #(
  parameter int unsigned STAGES = 32,
  parameter int unsigned PW     = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  logic          variant,
  output logic          overflow,
  output logic [PW-1:0] pending_new
);

  ssg_pkg::ssg_cell_stat_t stat [STAGES];
  logic [STAGES:0]         carry;
  logic [PW-1:0]           bin_cnt;
  logic                    tern_one;

  assign carry[0] = 1'b1;

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    ssg_digit_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .variant  (variant),
      .carry_in (carry[g]),
      .stat     (stat[g])
    );
    assign carry[g+1] = stat[g].carry_out;
  end

  assign overflow = carry[STAGES];

  // stop is one-hot (or empty on overflow): OR-encode its position
  always_comb begin
    bin_cnt  = overflow ? PW'(STAGES) : '0;
    tern_one = 1'b0;
    for (int i = 0; i < STAGES; i++) begin
      if (stat[i].stop) begin
        bin_cnt = bin_cnt | PW'(i);
      end
      tern_one = tern_one | stat[i].stop_on_one;
    end
  end

  assign pending_new = (variant == ssg_pkg::VAR_BINARY) ? bin_cnt : PW'(tern_one);

endmodule
